@@ rtl/rhh_pkg.sv @@
// shared constants, types and the hash function for the robin hood hash table
package rhh_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_BYTES_DEF  = 4;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int PSL_W     = 8;
    localparam logic [PSL_W-1:0] PROBE_LIMIT_RESET = 8'd16;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_DEL   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        cmd_t               cmd;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [63:0]        hash;
    } job_t;

    // one fnv-1a byte step; the prime has only bits 40, 8, 7, 5, 4, 1, 0 set
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ rtl/rhh_front.sv @@
// front end: accepts items, masks fields and hashes the key one byte per cycle
module rhh_front #(
    parameter int KEY_BYTES  = rhh_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rhh_pkg::CMD_W-1:0]     s_command,
    input  logic [rhh_pkg::KEY_W-1:0]     s_key,
    input  logic [rhh_pkg::VAL_W-1:0]     s_value,
    output logic                          job_valid,
    input  logic                          job_ready,
    output rhh_pkg::job_t                 job
);
    localparam int BCNT_W = $clog2(KEY_BYTES + 1);
    localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(KEY_BYTES - 1);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_OUT} fstate_t;

    fstate_t                    state_reg;
    logic [BCNT_W-1:0]          byte_reg;
    rhh_pkg::job_t              job_reg;
    logic [rhh_pkg::KEY_W-1:0]  kmask;
    logic [rhh_pkg::VAL_W-1:0]  vmask;
    logic [7:0]                 cur_byte;

    always_comb begin
        kmask = '1;
        vmask = '1;
        if (KEY_BYTES < 4) kmask = rhh_pkg::KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
        if (VALUE_BITS < 32) vmask = rhh_pkg::VAL_W'((64'd1 << VALUE_BITS) - 64'd1);
        cur_byte = 8'd0;
        if (32'(byte_reg) < 32'd4) cur_byte = 8'(job_reg.key >> {byte_reg, 3'b000});
    end

    assign s_ready   = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_OUT);
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            byte_reg  <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        job_reg.cmd   <= rhh_pkg::cmd_t'(s_command);
                        job_reg.key   <= s_key & kmask;
                        job_reg.value <= s_value & vmask;
                        job_reg.hash  <= rhh_pkg::FNV_BASIS;
                        byte_reg      <= '0;
                        state_reg     <= F_HASH;
                    end
                end
                F_HASH: begin
                    job_reg.hash <= rhh_pkg::fnv_step(job_reg.hash, cur_byte);
                    byte_reg     <= byte_reg + 1'b1;
                    if (byte_reg == LAST_BYTE) state_reg <= F_OUT;
                end
                F_OUT: begin
                    if (job_ready) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/rhh_queue.sv @@
// two-entry job queue between the front end and the table engine
module rhh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rhh_pkg::job_t  in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output rhh_pkg::job_t  out_job
);
    rhh_pkg::job_t mem_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/rhh_engine.sv @@
// back end: probes, inserts, deletes and clears the slot memories, one slot per step
module rhh_engine #(
    parameter int CAPACITY = rhh_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  rhh_pkg::job_t                     job,
    input  logic [rhh_pkg::PSL_W-1:0]         probe_limit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rhh_pkg::STATUS_W-1:0]      m_status,
    output logic [rhh_pkg::VAL_W-1:0]         m_value_out,
    output logic                              m_replaced,
    output logic [rhh_pkg::COUNT_W-1:0]       m_entry_count,
    output logic [rhh_pkg::PSL_W-1:0]         m_longest_probe_out
);
    localparam int SW = $clog2(CAPACITY);
    localparam int NW = $clog2(2 * CAPACITY + 1);
    localparam int PW = rhh_pkg::PSL_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        E_IDLE, E_READ, E_EVAL, E_SHREAD, E_SHEVAL, E_CLEAR, E_RESP
    } estate_t;

    logic [rhh_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [rhh_pkg::VAL_W-1:0] val_mem [CAPACITY];
    logic [PW-1:0]             psl_mem [CAPACITY];

    estate_t                    state_reg;
    rhh_pkg::cmd_t              cmd_reg;
    logic [rhh_pkg::KEY_W-1:0]  key_reg;
    logic [rhh_pkg::VAL_W-1:0]  val_reg;
    logic [SW-1:0]              slot_reg, prev_reg;
    logic [NW-1:0]              n_reg;
    logic [8:0]                 psl_reg;
    logic [rhh_pkg::KEY_W-1:0]  rk_reg;
    logic [rhh_pkg::VAL_W-1:0]  rv_reg;
    logic [PW-1:0]              rp_reg;
    logic [rhh_pkg::COUNT_W-1:0] count_reg;
    logic [PW-1:0]              longest_reg;
    logic [rhh_pkg::STATUS_W-1:0] st_reg;
    logic [rhh_pkg::VAL_W-1:0]  vout_reg;
    logic                       repl_reg;

    logic [SW-1:0]              next_slot;
    logic [PW-1:0]              psl_sat;
    logic [PW-1:0]              longest_next;
    logic                       is_full;

    // synchronous reset clears the probe lengths slot by slot in the clear state
    logic                       init_reg;

    always_comb begin
        next_slot    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        psl_sat      = (psl_reg > 9'd255) ? 8'hFF : psl_reg[PW-1:0];
        longest_next = (psl_reg > {1'b0, longest_reg}) ? psl_sat : longest_reg;
        is_full      = ((32'(count_reg) + 32'd1) * 32'd4 > 32'(CAPACITY) * 32'd3)
                       || (longest_reg >= probe_limit);
    end

    assign job_ready = (state_reg == E_IDLE) && !init_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_CLEAR;
            init_reg    <= 1'b1;
            slot_reg    <= '0;
            count_reg   <= '0;
            longest_reg <= '0;
            m_valid     <= 1'b0;
        end else begin
            unique case (state_reg)
                E_IDLE: begin
                    if (job_valid) begin
                        cmd_reg  <= job.cmd;
                        key_reg  <= job.key;
                        val_reg  <= job.value;
                        slot_reg <= (job.cmd == rhh_pkg::CMD_CLEAR) ? '0 : job.hash[SW-1:0];
                        psl_reg  <= 9'd1;
                        n_reg    <= '0;
                        st_reg   <= (job.cmd == rhh_pkg::CMD_SET && is_full) ?
                                    rhh_pkg::ST_FULL : rhh_pkg::ST_OK;
                        vout_reg <= '0;
                        repl_reg <= 1'b0;
                        unique case (job.cmd)
                            rhh_pkg::CMD_CLEAR: begin
                                count_reg   <= '0;
                                longest_reg <= '0;
                                state_reg   <= E_CLEAR;
                            end
                            rhh_pkg::CMD_SET: begin
                                state_reg <= is_full ? E_RESP : E_READ;
                            end
                            default: state_reg <= E_READ;
                        endcase
                    end
                end
                E_READ: begin
                    rk_reg    <= key_mem[slot_reg];
                    rv_reg    <= val_mem[slot_reg];
                    rp_reg    <= psl_mem[slot_reg];
                    state_reg <= E_EVAL;
                end
                E_EVAL: begin
                    if (cmd_reg == rhh_pkg::CMD_SET) begin
                        if (rp_reg == '0) begin
                            key_mem[slot_reg] <= key_reg;
                            val_mem[slot_reg] <= val_reg;
                            psl_mem[slot_reg] <= psl_sat;
                            longest_reg       <= longest_next;
                            count_reg         <= count_reg + 1'b1;
                            state_reg         <= E_RESP;
                        end else if (rk_reg == key_reg) begin
                            val_mem[slot_reg] <= val_reg;
                            repl_reg          <= 1'b1;
                            state_reg         <= E_RESP;
                        end else begin
                            if ({1'b0, rp_reg} < psl_reg) begin
                                key_mem[slot_reg] <= key_reg;
                                val_mem[slot_reg] <= val_reg;
                                psl_mem[slot_reg] <= psl_sat;
                                longest_reg       <= longest_next;
                                key_reg           <= rk_reg;
                                val_reg           <= rv_reg;
                                psl_reg           <= {1'b0, rp_reg} + 9'd1;
                            end else begin
                                psl_reg <= psl_reg + 9'd1;
                            end
                            slot_reg <= next_slot;
                            n_reg    <= n_reg + 1'b1;
                            if (32'(n_reg) == 2 * CAPACITY - 1) state_reg <= E_RESP;
                            else state_reg <= E_READ;
                        end
                    end else begin
                        // get and delete share the lookup
                        if (rp_reg == '0 || {1'b0, rp_reg} < psl_reg) begin
                            st_reg    <= rhh_pkg::ST_NOT_FOUND;
                            state_reg <= E_RESP;
                        end else if (rk_reg == key_reg) begin
                            if (cmd_reg == rhh_pkg::CMD_GET) begin
                                vout_reg  <= rv_reg;
                                state_reg <= E_RESP;
                            end else begin
                                psl_mem[slot_reg] <= '0;
                                if (count_reg != '0) count_reg <= count_reg - 1'b1;
                                prev_reg  <= slot_reg;
                                slot_reg  <= next_slot;
                                n_reg     <= '0;
                                state_reg <= E_SHREAD;
                            end
                        end else begin
                            slot_reg <= next_slot;
                            psl_reg  <= psl_reg + 9'd1;
                            n_reg    <= n_reg + 1'b1;
                            if (32'(n_reg) == CAPACITY - 1) begin
                                st_reg    <= rhh_pkg::ST_NOT_FOUND;
                                state_reg <= E_RESP;
                            end else begin
                                state_reg <= E_READ;
                            end
                        end
                    end
                end
                E_SHREAD: begin
                    rk_reg    <= key_mem[slot_reg];
                    rv_reg    <= val_mem[slot_reg];
                    rp_reg    <= psl_mem[slot_reg];
                    state_reg <= E_SHEVAL;
                end
                E_SHEVAL: begin
                    if (32'(n_reg) < CAPACITY && rp_reg > 8'd1) begin
                        key_mem[prev_reg] <= rk_reg;
                        val_mem[prev_reg] <= rv_reg;
                        psl_mem[prev_reg] <= rp_reg - 1'b1;
                        prev_reg  <= slot_reg;
                        slot_reg  <= next_slot;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= E_SHREAD;
                    end else begin
                        // the last entry moved down leaves its old slot empty
                        psl_mem[prev_reg] <= '0;
                        state_reg         <= E_RESP;
                    end
                end
                E_CLEAR: begin
                    psl_mem[slot_reg] <= '0;
                    slot_reg          <= next_slot;
                    if (slot_reg == LAST_SLOT) begin
                        if (init_reg) begin
                            init_reg  <= 1'b0;
                            state_reg <= E_IDLE;
                        end else begin
                            state_reg <= E_RESP;
                        end
                    end
                end
                E_RESP: begin
                    if (!m_valid || m_ready) begin
                        m_valid             <= 1'b1;
                        m_status            <= st_reg;
                        m_value_out         <= vout_reg;
                        m_replaced          <= repl_reg;
                        m_entry_count       <= count_reg;
                        m_longest_probe_out <= longest_reg;
                        state_reg           <= E_IDLE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
            if (m_valid && m_ready && !(state_reg == E_RESP)) m_valid <= 1'b0;
        end
    end
endmodule

@@ rtl/robin_hood_hash_table.sv @@
// top level of the robin hood hash table: config register, front end, queue, engine
// the key is hashed byte by byte; each probed or shifted slot is read then evaluated
// the engine works on one item at a time; a clear zeroes probe lengths slot by slot
// the front end hashes the next item while the engine probes the slot memory
// reset (synchronous, aresetn low) clears the table slot by slot,
// during which the engine takes no job; probe_limit resets to 16
module robin_hood_hash_table #(
    parameter int CAPACITY   = rhh_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = rhh_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rhh_pkg::PSL_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rhh_pkg::CMD_W-1:0]     s_command,
    input  logic [rhh_pkg::KEY_W-1:0]     s_key,
    input  logic [rhh_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhh_pkg::STATUS_W-1:0]  m_status,
    output logic [rhh_pkg::VAL_W-1:0]     m_value_out,
    output logic                          m_replaced,
    output logic [rhh_pkg::COUNT_W-1:0]   m_entry_count,
    output logic [rhh_pkg::PSL_W-1:0]     m_longest_probe_out
);
    logic [rhh_pkg::PSL_W-1:0] probe_limit_reg;
    logic                      fq_valid, fq_ready, qe_valid, qe_ready;
    rhh_pkg::job_t             fq_job, qe_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_limit_reg <= rhh_pkg::PROBE_LIMIT_RESET;
        end else if (cfg_valid) begin
            probe_limit_reg <= cfg_data;
        end
    end

    rhh_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_key, .s_value,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    rhh_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qe_valid), .out_ready(qe_ready), .out_job(qe_job)
    );

    rhh_engine #(.CAPACITY(CAPACITY)) u_engine (
        .aclk, .aresetn,
        .job_valid(qe_valid), .job_ready(qe_ready), .job(qe_job),
        .probe_limit(probe_limit_reg),
        .m_valid, .m_ready, .m_status, .m_value_out, .m_replaced,
        .m_entry_count, .m_longest_probe_out
    );
endmodule
